// ===== design/seir_rk4_step_top_defines.svh =====
// Assertion macros for the SEIR Runge-Kutta step block.
// Used by the port checker; depends on nets named aclk and aresetn in scope.
`ifndef SEIR_RK4_STEP_TOP_DEFINES_SVH
`define SEIR_RK4_STEP_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SEIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SEIR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/seir_pkg.sv =====
// Shared types, constants and the micro-program of the SEIR Runge-Kutta step.
// No dependencies; used by seir_mul, seir_div6 and seir_rk4_step_top.
`default_nettype none

package seir_pkg;

    localparam int POP_W     = 64;
    localparam int DT_W      = 32;
    localparam int RATE_W    = 48;
    localparam int RECR_W    = 63;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int POP_FRAC  = 24;
    localparam int RATE_FRAC = 44;
    localparam int SLOT_N    = 32;
    localparam int SLOT_W    = 5;

    // Division by six as a product with a rounded-up reciprocal of 6 / 2^66.
    localparam logic [POP_W-1:0] DIV6_RECIP = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam int               DIV6_SHIFT = 66;

    localparam logic [POP_W-1:0] POP_MAX = {1'b0, {(POP_W-1){1'b1}}};
    localparam logic [POP_W-1:0] POP_MIN = {1'b1, {(POP_W-1){1'b0}}};

    // Register indexes.
    localparam logic [2:0] CFG_RECRUIT  = 3'd0;
    localparam logic [2:0] CFG_CONTACT  = 3'd1;
    localparam logic [2:0] CFG_INCUB    = 3'd2;
    localparam logic [2:0] CFG_RECOVER  = 3'd3;
    localparam logic [2:0] CFG_NAT_DEATH = 3'd4;
    localparam logic [2:0] CFG_DIS_DEATH = 3'd5;
    localparam logic [2:0] CFG_PART_VAX = 3'd6;
    localparam logic [2:0] CFG_FULL_VAX = 3'd7;

    // Sources of a load and targets of a store.
    localparam logic [2:0] LD_S   = 3'd0;
    localparam logic [2:0] LD_E   = 3'd1;
    localparam logic [2:0] LD_I   = 3'd2;
    localparam logic [2:0] LD_R   = 3'd3;
    localparam logic [2:0] LD_REC = 3'd4;

    // Scratch slots.
    localparam logic [4:0] SL_Y   = 5'd0;
    localparam logic [4:0] SL_P   = 5'd4;
    localparam logic [4:0] SL_K   = 5'd8;
    localparam logic [4:0] SL_INF = 5'd24;
    localparam logic [4:0] SL_T   = 5'd25;
    localparam logic [4:0] SL_M   = 5'd26;
    localparam logic [4:0] SL_M2  = 5'd27;
    localparam logic [4:0] SL_REC = 5'd28;

    typedef enum logic [3:0] {
        OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_MRATE, OP_MPOP,
        OP_MTH, OP_MTF, OP_DIV6, OP_END
    } op_t;

    typedef enum logic [2:0] {
        SEG_INIT, SEG_DERIV, SEG_POINT, SEG_FINAL, SEG_STORE, SEG_TOTAL
    } seg_t;

    typedef enum logic [1:0] {
        SC_POP, SC_RATE, SC_DIV6
    } scale_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  sel;
        logic [4:0]  src_a;
        logic [4:0]  src_b;
        logic [4:0]  dst;
    } uop_t;

    typedef struct packed {
        logic [POP_W-1:0] a;
        logic [POP_W-1:0] b;
        logic             neg;
        scale_t           scale;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [POP_W-1:0] value;
    } mul_rsp_t;

    function automatic uop_t mk(input op_t op, input logic [2:0] sel,
                                input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] d);
        uop_t u;
        u.op    = op;
        u.sel   = sel;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        return u;
    endfunction

    // Derivative of the four compartments at slots xb..xb+3 into db..db+3.
    function automatic uop_t deriv_uop(input logic [4:0] step, input logic [4:0] xb,
                                       input logic [4:0] db);
        uop_t u;
        logic [4:0] x0, x1, x2, x3;
        x0 = xb;
        x1 = xb + 5'd1;
        x2 = xb + 5'd2;
        x3 = xb + 5'd3;
        unique case (step)
            5'd0:  u = mk(OP_MRATE, CFG_CONTACT, x0, x0, SL_M);
            5'd1:  u = mk(OP_MPOP, 3'd0, SL_M, x2, SL_INF);
            5'd2:  u = mk(OP_SUB, 3'd0, SL_REC, SL_INF, SL_T);
            5'd3:  u = mk(OP_MRATE, CFG_NAT_DEATH, x0, x0, SL_M);
            5'd4:  u = mk(OP_SUB, 3'd0, SL_T, SL_M, SL_T);
            5'd5:  u = mk(OP_MRATE, CFG_PART_VAX, x0, x0, SL_M);
            5'd6:  u = mk(OP_SUB, 3'd0, SL_T, SL_M, SL_T);
            5'd7:  u = mk(OP_MRATE, CFG_FULL_VAX, x0, x0, SL_M);
            5'd8:  u = mk(OP_SUB, 3'd0, SL_T, SL_M, db);
            5'd9:  u = mk(OP_MRATE, CFG_NAT_DEATH, x1, x1, SL_M);
            5'd10: u = mk(OP_SUB, 3'd0, SL_INF, SL_M, SL_T);
            5'd11: u = mk(OP_MRATE, CFG_INCUB, x1, x1, SL_M);
            5'd12: u = mk(OP_SUB, 3'd0, SL_T, SL_M, SL_T);
            5'd13: u = mk(OP_MRATE, CFG_PART_VAX, x0, x0, SL_M);
            5'd14: u = mk(OP_ADD, 3'd0, SL_T, SL_M, db + 5'd1);
            5'd15: u = mk(OP_MRATE, CFG_INCUB, x1, x1, SL_T);
            5'd16: u = mk(OP_MRATE, CFG_NAT_DEATH, x2, x2, SL_M);
            5'd17: u = mk(OP_SUB, 3'd0, SL_T, SL_M, SL_T);
            5'd18: u = mk(OP_MRATE, CFG_DIS_DEATH, x2, x2, SL_M);
            5'd19: u = mk(OP_SUB, 3'd0, SL_T, SL_M, SL_T);
            5'd20: u = mk(OP_MRATE, CFG_RECOVER, x2, x2, SL_M);
            5'd21: u = mk(OP_SUB, 3'd0, SL_T, SL_M, db + 5'd2);
            5'd22: u = mk(OP_MRATE, CFG_FULL_VAX, x0, x0, SL_T);
            5'd23: u = mk(OP_MRATE, CFG_RECOVER, x2, x2, SL_M);
            5'd24: u = mk(OP_ADD, 3'd0, SL_T, SL_M, SL_T);
            5'd25: u = mk(OP_MRATE, CFG_NAT_DEATH, x3, x3, SL_M);
            5'd26: u = mk(OP_SUB, 3'd0, SL_T, SL_M, db + 5'd3);
            default: u = mk(OP_END, 3'd0, SL_T, SL_T, SL_T);
        endcase
        return u;
    endfunction

    function automatic logic [4:0] seg_last(input seg_t seg);
        logic [4:0] n;
        unique case (seg)
            SEG_INIT:  n = 5'd4;
            SEG_DERIV: n = 5'd26;
            SEG_POINT: n = 5'd7;
            SEG_FINAL: n = 5'd31;
            SEG_STORE: n = 5'd3;
            SEG_TOTAL: n = 5'd7;
            default:   n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic uop_t fetch_uop(input seg_t seg, input logic [1:0] stage,
                                       input logic [4:0] step);
        uop_t u;
        logic [4:0] kb, kn, yn, pn;
        logic [1:0] n;
        kb = SL_K + {1'b0, stage, 2'b00};
        n  = (seg == SEG_POINT) ? step[2:1] : (seg == SEG_FINAL) ? step[4:3] : step[1:0];
        kn = kb + {3'd0, n};
        yn = SL_Y + {3'd0, n};
        pn = SL_P + {3'd0, n};
        unique case (seg)
            SEG_INIT: begin
                if (step == 5'd4) u = mk(OP_LOAD, LD_REC, SL_REC, SL_REC, SL_REC);
                else u = mk(OP_LOAD, {1'b0, n}, yn, yn, yn);
            end
            SEG_DERIV: u = deriv_uop(step, (stage == 2'd0) ? SL_Y : SL_P, kb);
            SEG_POINT: begin
                if (!step[0]) begin
                    u = mk((stage == 2'd2) ? OP_MTF : OP_MTH, 3'd0, kn, kn, SL_M);
                end else begin
                    u = mk(OP_ADD, 3'd0, yn, SL_M, pn);
                end
            end
            SEG_FINAL: begin
                unique case (step[2:0])
                    3'd0: u = mk(OP_ADD, 3'd0, SL_K + 5'd4 + {3'd0, n},
                                 SL_K + 5'd4 + {3'd0, n}, SL_M2);
                    3'd1: u = mk(OP_ADD, 3'd0, SL_K + {3'd0, n}, SL_M2, SL_T);
                    3'd2: u = mk(OP_ADD, 3'd0, SL_K + 5'd8 + {3'd0, n},
                                 SL_K + 5'd8 + {3'd0, n}, SL_M2);
                    3'd3: u = mk(OP_ADD, 3'd0, SL_T, SL_M2, SL_T);
                    3'd4: u = mk(OP_ADD, 3'd0, SL_T, SL_K + 5'd12 + {3'd0, n}, SL_T);
                    3'd5: u = mk(OP_MTF, 3'd0, SL_T, SL_T, SL_M);
                    3'd6: u = mk(OP_DIV6, 3'd0, SL_M, SL_M, SL_M);
                    default: u = mk(OP_ADD, 3'd0, yn, SL_M, pn);
                endcase
            end
            SEG_STORE: u = mk(OP_STORE, {1'b0, n}, pn, pn, pn);
            SEG_TOTAL: begin
                unique case (step[2:0])
                    3'd4: u = mk(OP_ADD, 3'd0, SL_Y, SL_Y + 5'd1, SL_T);
                    3'd5: u = mk(OP_ADD, 3'd0, SL_T, SL_Y + 5'd2, SL_T);
                    3'd6: u = mk(OP_ADD, 3'd0, SL_T, SL_Y + 5'd3, SL_T);
                    3'd7: u = mk(OP_END, 3'd0, SL_T, SL_T, SL_T);
                    default: u = mk(OP_LOAD, {1'b0, n}, yn, yn, yn);
                endcase
            end
            default: u = mk(OP_END, 3'd0, SL_T, SL_T, SL_T);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== design/seir_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// No dependencies.
`default_nettype none

module seir_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== design/seir_mul.sv =====
// Shared multiplier: 64 by 64 magnitude product from four 32 by 32 partial
// products, scaled right, signed and saturated. Depends on seir_pkg.
`default_nettype none

module seir_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire seir_pkg::mul_req_t req,
    output seir_pkg::mul_rsp_t      rsp
);

    logic                         busy_reg;
    logic [2:0]                   cnt_reg;
    logic [seir_pkg::POP_W-1:0]   a_reg, b_reg;
    logic                         neg_reg;
    seir_pkg::scale_t             scale_reg;
    logic [63:0]                  pp_reg;
    logic [1:0]                   ppsh_reg;
    logic [127:0]                 acc_reg;
    logic [31:0]                  a_half, b_half;
    logic [63:0]                  prod;
    logic [127:0]                 addend, q;
    logic [63:0]                  qhi, qlo;
    logic                         big;

    assign a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
    assign prod   = a_half * b_half;

    always_comb begin
        unique case (ppsh_reg)
            2'd1:    addend = {32'd0, pp_reg, 32'd0};
            2'd2:    addend = {pp_reg, 64'd0};
            default: addend = {64'd0, pp_reg};
        endcase
    end

    always_comb begin
        unique case (scale_reg)
            seir_pkg::SC_RATE: q = acc_reg >> seir_pkg::RATE_FRAC;
            seir_pkg::SC_DIV6: q = acc_reg >> seir_pkg::DIV6_SHIFT;
            default:           q = acc_reg >> seir_pkg::POP_FRAC;
        endcase
    end

    assign qhi = q[127:64];
    assign qlo = q[63:0];

    always_comb begin
        if (neg_reg) begin
            big       = (qhi != 64'd0) || (qlo > seir_pkg::POP_MIN);
            rsp.value = big ? seir_pkg::POP_MIN : (64'd0 - qlo);
        end else begin
            big       = (qhi != 64'd0) || qlo[63];
            rsp.value = big ? seir_pkg::POP_MAX : qlo;
        end
        rsp.sat  = big;
        rsp.done = busy_reg && (cnt_reg == 3'd5);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else if (start && !busy_reg) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= 3'd0;
            a_reg     <= req.a;
            b_reg     <= req.b;
            neg_reg   <= req.neg;
            scale_reg <= req.scale;
            acc_reg   <= 128'd0;
        end else if (busy_reg) begin
            if (cnt_reg < 3'd4) begin
                pp_reg   <= prod;
                ppsh_reg <= {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
            end
            if (cnt_reg != 3'd0 && cnt_reg != 3'd5) begin
                acc_reg <= acc_reg + addend;
            end
            if (cnt_reg == 3'd5) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/seir_div6.sv =====
// Signed division by six, truncated toward zero, as a request to the shared
// multiplier: the magnitude times a scaled reciprocal. Depends on seir_pkg.
`default_nettype none

module seir_div6 (
    input  wire logic [seir_pkg::POP_W-1:0] value,
    output seir_pkg::mul_req_t              req
);

    always_comb begin
        req.a     = value[63] ? (64'd0 - value) : value;
        req.b     = seir_pkg::DIV6_RECIP;
        req.neg   = value[63];
        req.scale = seir_pkg::SC_DIV6;
    end

endmodule

`default_nettype wire

// ===== design/seir_rk4_step_top.sv =====
// Top level of the SEIR Runge-Kutta step block: sequencer, state and ports.
// Depends on seir_pkg, seir_ram, seir_mul and seir_div6.
//
// Usage. Rates are written on the cfg port while the block is idle. An input
// item with s_tuser low loads S, E, I, R and the step time; one with s_tuser
// high advances the model by one fourth-order Runge-Kutta step. Each item
// gives exactly one result item: the four compartments, their saturated sum
// and a flag in m_tuser that is set when any value saturated.
// A small sequencer runs a fixed micro-program over a 32-entry scratch RAM and
// one shared multiplier, which also does the divisions by six. A simple
// operation passes through a read and an execute state; a product or a
// division then waits for the multiplier. A load item runs 8 simple
// operations and an advance item 76 products, 4 divisions and 101 simple
// operations. The next item can be accepted in the cycle after the result
// is taken.
// One item is processed at a time: s_tready is high only while idle, and the
// result stays on m_tdata with m_tvalid high until the receiver takes it.
// Synchronous reset clears the rates, the compartments and the step time and
// returns the block to idle with no result pending.
`default_nettype none

module seir_rk4_step_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // load_susceptible, load_exposed, load_infected, load_recovered, load_step_time
    input  wire logic [287:0] s_tdata,
    // func
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // susceptible, exposed, infected, recovered, total
    output logic      [319:0] m_tdata,
    // overflow
    output logic              m_tuser,
    input  wire logic         cfg_we,
    input  wire logic [seir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [seir_pkg::RECR_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EXEC, ST_WAIT, ST_OUT} state_t;

    state_t                       state_reg;
    seir_pkg::seg_t               seg_reg, seg_next;
    logic [1:0]                   stage_reg, stage_next;
    logic [4:0]                   step_reg, step_next;
    logic [seir_pkg::POP_W-1:0]   s_reg, e_reg, i_reg, r_reg, total_reg;
    logic [seir_pkg::DT_W-1:0]    dt_reg;
    logic [seir_pkg::RECR_W-1:0]  recr_reg;
    logic [seir_pkg::RATE_W-1:0]  rate_reg [seir_pkg::NUM_REGS];
    logic                         ovf_reg;

    seir_pkg::uop_t               uop;
    logic                         ram_we;
    logic [seir_pkg::POP_W-1:0]   ram_wdata, rdata_a, rdata_b, ld_val, add_res;
    logic [seir_pkg::POP_W-1:0]   mag_a, mag_b;
    logic [64:0]                  sum65;
    logic                         add_sat, mul_start, unit_done;
    logic [seir_pkg::DT_W-1:0]    t_val;
    seir_pkg::mul_req_t           mul_req, div_req;
    seir_pkg::mul_rsp_t           mul_rsp;

    assign uop = seir_pkg::fetch_uop(seg_reg, stage_reg, step_reg);

    seir_ram #(
        .WIDTH(seir_pkg::POP_W),
        .DEPTH(seir_pkg::SLOT_N)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (uop.dst),
        .wdata   (ram_wdata),
        .raddr_a (uop.src_a),
        .raddr_b (uop.src_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    seir_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    seir_div6 u_div (
        .value   (rdata_a),
        .req     (div_req)
    );

    assign mag_a = rdata_a[63] ? (64'd0 - rdata_a) : rdata_a;
    assign mag_b = rdata_b[63] ? (64'd0 - rdata_b) : rdata_b;
    assign t_val = (uop.op == seir_pkg::OP_MTH) ? {1'b0, dt_reg[31:1]} : dt_reg;

    always_comb begin
        mul_req.a     = mag_a;
        mul_req.b     = {32'd0, t_val};
        mul_req.neg   = rdata_a[63];
        mul_req.scale = seir_pkg::SC_POP;
        if (uop.op == seir_pkg::OP_MRATE) begin
            mul_req.a     = {16'd0, rate_reg[uop.sel]};
            mul_req.b     = mag_a;
            mul_req.scale = seir_pkg::SC_RATE;
        end else if (uop.op == seir_pkg::OP_MPOP) begin
            mul_req.b   = mag_b;
            mul_req.neg = rdata_a[63] ^ rdata_b[63];
        end else if (uop.op == seir_pkg::OP_DIV6) begin
            mul_req = div_req;
        end
    end

    // Saturating add and subtract.
    always_comb begin
        if (uop.op == seir_pkg::OP_SUB) sum65 = {rdata_a[63], rdata_a} - {rdata_b[63], rdata_b};
        else sum65 = {rdata_a[63], rdata_a} + {rdata_b[63], rdata_b};
        add_sat = sum65[64] ^ sum65[63];
        add_res = add_sat ? (sum65[64] ? seir_pkg::POP_MIN : seir_pkg::POP_MAX) : sum65[63:0];
    end

    always_comb begin
        unique case (uop.sel)
            seir_pkg::LD_S:   ld_val = s_reg;
            seir_pkg::LD_E:   ld_val = e_reg;
            seir_pkg::LD_I:   ld_val = i_reg;
            seir_pkg::LD_R:   ld_val = r_reg;
            seir_pkg::LD_REC: ld_val = {1'b0, recr_reg};
            default:          ld_val = 64'd0;
        endcase
    end

    assign unit_done = mul_rsp.done;

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = add_res;
        mul_start = 1'b0;
        if (state_reg == ST_EXEC) begin
            unique case (uop.op)
                seir_pkg::OP_LOAD: begin
                    ram_we    = 1'b1;
                    ram_wdata = ld_val;
                end
                seir_pkg::OP_ADD, seir_pkg::OP_SUB: ram_we = 1'b1;
                seir_pkg::OP_MRATE, seir_pkg::OP_MPOP,
                seir_pkg::OP_MTH, seir_pkg::OP_MTF,
                seir_pkg::OP_DIV6: mul_start = 1'b1;
                default: ;
            endcase
        end else if (state_reg == ST_WAIT && unit_done) begin
            ram_we    = 1'b1;
            ram_wdata = mul_rsp.value;
        end
    end

    // Next micro-operation.
    always_comb begin
        seg_next   = seg_reg;
        stage_next = stage_reg;
        step_next  = step_reg + 5'd1;
        if (step_reg == seir_pkg::seg_last(seg_reg)) begin
            step_next = 5'd0;
            unique case (seg_reg)
                seir_pkg::SEG_INIT:  seg_next = seir_pkg::SEG_DERIV;
                seir_pkg::SEG_DERIV: begin
                    seg_next = (stage_reg == 2'd3) ? seir_pkg::SEG_FINAL : seir_pkg::SEG_POINT;
                end
                seir_pkg::SEG_POINT: begin
                    seg_next   = seir_pkg::SEG_DERIV;
                    stage_next = stage_reg + 2'd1;
                end
                seir_pkg::SEG_FINAL: seg_next = seir_pkg::SEG_STORE;
                default:             seg_next = seir_pkg::SEG_TOTAL;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seg_reg   <= seir_pkg::SEG_TOTAL;
            stage_reg <= 2'd0;
            step_reg  <= 5'd0;
            s_reg     <= 64'd0;
            e_reg     <= 64'd0;
            i_reg     <= 64'd0;
            r_reg     <= 64'd0;
            total_reg <= 64'd0;
            dt_reg    <= 32'd0;
            recr_reg  <= '0;
            ovf_reg   <= 1'b0;
            for (int k = 0; k < seir_pkg::NUM_REGS; k++) begin
                rate_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == seir_pkg::CFG_RECRUIT) recr_reg <= cfg_data;
                rate_reg[cfg_index] <= cfg_data[seir_pkg::RATE_W-1:0];
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ovf_reg   <= 1'b0;
                        stage_reg <= 2'd0;
                        step_reg  <= 5'd0;
                        state_reg <= ST_READ;
                        if (!s_tuser) begin
                            s_reg   <= s_tdata[63:0];
                            e_reg   <= s_tdata[127:64];
                            i_reg   <= s_tdata[191:128];
                            r_reg   <= s_tdata[255:192];
                            dt_reg  <= s_tdata[287:256];
                            seg_reg <= seir_pkg::SEG_TOTAL;
                        end else begin
                            seg_reg <= seir_pkg::SEG_INIT;
                        end
                    end
                end
                ST_READ: state_reg <= ST_EXEC;
                ST_EXEC: begin
                    unique case (uop.op)
                        seir_pkg::OP_MRATE, seir_pkg::OP_MPOP, seir_pkg::OP_MTH,
                        seir_pkg::OP_MTF, seir_pkg::OP_DIV6: state_reg <= ST_WAIT;
                        seir_pkg::OP_END: begin
                            total_reg <= rdata_a;
                            state_reg <= ST_OUT;
                        end
                        default: begin
                            if (uop.op == seir_pkg::OP_STORE) begin
                                unique case (uop.sel[1:0])
                                    seir_pkg::LD_S[1:0]: s_reg <= rdata_a;
                                    seir_pkg::LD_E[1:0]: e_reg <= rdata_a;
                                    seir_pkg::LD_I[1:0]: i_reg <= rdata_a;
                                    default:             r_reg <= rdata_a;
                                endcase
                            end
                            if (uop.op == seir_pkg::OP_ADD || uop.op == seir_pkg::OP_SUB) begin
                                ovf_reg <= ovf_reg | add_sat;
                            end
                            seg_reg   <= seg_next;
                            stage_reg <= stage_next;
                            step_reg  <= step_next;
                            state_reg <= ST_READ;
                        end
                    endcase
                end
                ST_WAIT: begin
                    if (unit_done) begin
                        ovf_reg   <= ovf_reg | mul_rsp.sat;
                        seg_reg   <= seg_next;
                        stage_reg <= stage_next;
                        step_reg  <= step_next;
                        state_reg <= ST_READ;
                    end
                end
                default: begin
                    if (m_tready) state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {total_reg, r_reg, i_reg, e_reg, s_reg};
    assign m_tuser  = ovf_reg;

endmodule

`default_nettype wire

// ===== design/seir_chk.sv =====
// Port checker for the SEIR Runge-Kutta step block, bound to the top level.
// Depends on seir_rk4_step_top_defines.svh and seir_rk4_step_top.
`default_nettype none

`include "seir_rk4_step_top_defines.svh"

module seir_chk (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [319:0] m_tdata
);

    `SEIR_ASSERT(a_one_item, m_tvalid |-> !s_tready, "item taken while a result waits")
    `SEIR_ASSERT(a_no_instant, (s_tvalid && s_tready) |=> !m_tvalid, "result in the cycle after accept")
    `SEIR_ASSERT(a_back_idle, (m_tvalid && m_tready) |=> s_tready, "not idle after result taken")
    `SEIR_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `SEIR_ASSERT_RST(a_reset, !aresetn |=> (!m_tvalid && s_tready), "not idle after reset")

endmodule

bind seir_rk4_step_top seir_chk u_seir_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
